>>> design/pps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pps_pkg;

  // field and datapath widths
  localparam int CLK_W   = 29;
  localparam int F_W     = 39;
  localparam int PRE_W   = 17;
  localparam int PER_W   = 32;
  localparam int NUM_W   = 42;
  localparam int DEN_W   = 40;
  localparam int CNT_W   = $clog2(NUM_W);
  localparam int CM_W    = 10;
  localparam int SM_W    = 10;
  localparam int SCALE_W = 30;
  localparam int IDX_W   = 2;

  localparam int unsigned MAX_CLK_MHZ = 216;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_TIMER_CLOCK  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_COUNTER_WIDE = IDX_W'(1);

  localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(108000000);

  // time scales
  localparam logic [SCALE_W-1:0] SCALE_NS = SCALE_W'(1000000000);
  localparam logic [SCALE_W-1:0] SCALE_US = SCALE_W'(1000000);
  localparam logic [SCALE_W-1:0] SCALE_MS = SCALE_W'(1000);
  localparam logic [SCALE_W-1:0] MEGA     = SCALE_W'(1000000);

  localparam logic [F_W-1:0] F_NS_MIN = F_W'(1000000);
  localparam logic [F_W-1:0] F_US_MIN = F_W'(1000);

  // doubled numerators for rounded base period
  localparam logic [NUM_W-1:0] RNUM_NS = NUM_W'(64'd2000000000000);
  localparam logic [NUM_W-1:0] RNUM_US = NUM_W'(64'd2000000000);
  localparam logic [NUM_W-1:0] RNUM_MS = NUM_W'(64'd2000000);

  localparam logic [SM_W-1:0] SM_NS = SM_W'(1000000000 / 1000000);
  localparam logic [SM_W-1:0] SM_US = SM_W'(1000000 / 1000000);

  localparam logic [PER_W-1:0] P_MUL_LIMIT = PER_W'(64'hFFFF_FFFF / 64'(MAX_CLK_MHZ));

  localparam logic [CLK_W-1:0] PRE_HALVE_MAX  = CLK_W'(32'h10000);
  localparam logic [CLK_W-1:0] PRE_DOUBLE_MAX = CLK_W'(32'h8000);
  localparam logic [PER_W-1:0] P_NARROW_LIM   = PER_W'(32'h10000);

  localparam logic [NUM_W-1:0] KILO = NUM_W'(1000);

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic             valid;
    logic             solved;
    logic [PRE_W-1:0] prescale_div;
    logic [PER_W-1:0] period_count;
    logic [CLK_W-1:0] achieved_hz;
  } pps_res_t;

endpackage
`default_nettype wire

>>> design/pps_divider.sv
`timescale 1ns / 1ps
`default_nettype none
module pps_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pps_pkg::div_req_t req,
  output pps_pkg::div_rsp_t      rsp
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [pps_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [pps_pkg::DEN_W-1:0]    rem_r, rem_nxt;
  logic [pps_pkg::DEN_W-1:0]    den_r, den_nxt;
  logic [pps_pkg::NUM_W-1:0]    quo_r, quo_nxt;

  logic [pps_pkg::DEN_W:0]      shifted;
  logic [pps_pkg::DEN_W+1:0]    diff;
  logic                         ge;

  // one quotient bit per cycle, restoring
  assign shifted = {rem_r, quo_r[pps_pkg::NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};
  assign ge      = ~diff[pps_pkg::DEN_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = pps_pkg::CNT_W'(pps_pkg::NUM_W - 1);
      rem_nxt  = '0;
      den_nxt  = req.den;
      quo_nxt  = req.num;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[pps_pkg::DEN_W-1:0] : shifted[pps_pkg::DEN_W-1:0];
      quo_nxt = {quo_r[pps_pkg::NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule
`default_nettype wire

>>> design/pps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pps_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start_i,
  input  wire logic [pps_pkg::F_W-1:0]   f_i,
  input  wire logic [pps_pkg::CLK_W-1:0] clk_hz_i,
  input  wire logic                      wide_i,
  output logic                           idle_o,
  output pps_pkg::pps_res_t              res_o,
  input  wire logic                      res_take_i,
  output pps_pkg::div_req_t              div_req_o,
  input  wire pps_pkg::div_rsp_t         div_rsp_i
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_BASE   = 13'b0000000000010,
    S_PRE    = 13'b0000000000100,
    S_CM     = 13'b0000000001000,
    S_PSM    = 13'b0000000010000,
    S_HALVE  = 13'b0000000100000,
    S_NARROW = 13'b0000001000000,
    S_CQ     = 13'b0000010000000,
    S_D      = 13'b0000100000000,
    S_P2     = 13'b0001000000000,
    S_A      = 13'b0010000000000,
    S_CHECK  = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [pps_pkg::F_W-1:0]       f_r, f_nxt;
  logic [pps_pkg::SCALE_W-1:0]   scale_r, scale_nxt;
  logic [pps_pkg::PER_W-1:0]     base_r, base_nxt;
  logic [pps_pkg::PER_W-1:0]     p_r, p_nxt;
  logic [pps_pkg::CLK_W-1:0]     pre_r, pre_nxt;
  logic [pps_pkg::CLK_W-1:0]     cq_r, cq_nxt;
  logic [pps_pkg::PER_W-1:0]     p2_r, p2_nxt;
  logic [pps_pkg::PER_W-1:0]     a_r, a_nxt;
  logic                          ok_r, ok_nxt;

  logic [pps_pkg::SM_W-1:0]      sm;
  logic [pps_pkg::CM_W-1:0]      cm;
  logic [pps_pkg::NUM_W-1:0]     prod;
  logic [pps_pkg::NUM_W-1:0]     a_k;
  logic [pps_pkg::PER_W-1:0]     p_inc;
  logic [pps_pkg::PER_W-1:0]     quo32;

  always_comb begin
    case (scale_r)
      pps_pkg::SCALE_NS: sm = pps_pkg::SM_NS;
      pps_pkg::SCALE_US: sm = pps_pkg::SM_US;
      default:           sm = '0;
    endcase
  end

  assign quo32 = div_rsp_i.quo[pps_pkg::PER_W-1:0];
  assign cm    = div_rsp_i.quo[pps_pkg::CM_W-1:0];
  assign prod  = pps_pkg::NUM_W'(p_r) * pps_pkg::NUM_W'(cm);
  assign a_k   = pps_pkg::NUM_W'(a_r) * pps_pkg::KILO;
  assign p_inc = p_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    f_nxt     = f_r;
    scale_nxt = scale_r;
    base_nxt  = base_r;
    p_nxt     = p_r;
    pre_nxt   = pre_r;
    cq_nxt    = cq_r;
    p2_nxt    = p2_r;
    a_nxt     = a_r;
    ok_nxt    = ok_r;
    div_req_o = '0;

    case (state_r)
      S_IDLE: begin
        if (start_i) begin
          f_nxt  = f_i;
          ok_nxt = 1'b0;
          if (f_i == '0) begin
            state_nxt = S_DONE;
          end else begin
            div_req_o.start = 1'b1;
            div_req_o.den   = {f_i, 1'b0};
            if (f_i >= pps_pkg::F_NS_MIN) begin
              scale_nxt     = pps_pkg::SCALE_NS;
              div_req_o.num = pps_pkg::RNUM_NS + pps_pkg::NUM_W'(f_i);
            end else if (f_i >= pps_pkg::F_US_MIN) begin
              scale_nxt     = pps_pkg::SCALE_US;
              div_req_o.num = pps_pkg::RNUM_US + pps_pkg::NUM_W'(f_i);
            end else begin
              scale_nxt     = pps_pkg::SCALE_MS;
              div_req_o.num = pps_pkg::RNUM_MS + pps_pkg::NUM_W'(f_i);
            end
            state_nxt = S_BASE;
          end
        end
      end
      S_BASE: begin
        if (div_rsp_i.done) begin
          base_nxt        = quo32;
          p_nxt           = quo32;
          div_req_o.start = 1'b1;
          div_req_o.num   = pps_pkg::NUM_W'(clk_hz_i);
          div_req_o.den   = pps_pkg::DEN_W'(scale_r);
          state_nxt       = S_PRE;
        end
      end
      S_PRE: begin
        if (div_rsp_i.done) begin
          if (div_rsp_i.quo == '0) begin
            if (sm == '0) begin
              state_nxt = S_DONE;
            end else begin
              div_req_o.start = 1'b1;
              div_req_o.num   = pps_pkg::NUM_W'(clk_hz_i);
              div_req_o.den   = pps_pkg::DEN_W'(pps_pkg::MEGA);
              state_nxt       = S_CM;
            end
          end else begin
            pre_nxt   = div_rsp_i.quo[pps_pkg::CLK_W-1:0];
            state_nxt = S_HALVE;
          end
        end
      end
      S_CM: begin
        if (div_rsp_i.done) begin
          div_req_o.start = 1'b1;
          div_req_o.den   = pps_pkg::DEN_W'(sm);
          if (p_r > pps_pkg::P_MUL_LIMIT) begin
            pre_nxt       = pps_pkg::CLK_W'(cm);
            div_req_o.num = pps_pkg::NUM_W'(p_r);
          end else begin
            pre_nxt       = pps_pkg::CLK_W'(1);
            div_req_o.num = pps_pkg::NUM_W'(prod[pps_pkg::PER_W-1:0]);
          end
          state_nxt = S_PSM;
        end
      end
      S_PSM: begin
        if (div_rsp_i.done) begin
          p_nxt     = quo32;
          state_nxt = S_NARROW;
        end
      end
      S_HALVE: begin
        // bring the prescaler down to 0x10000, trading into the period
        if (pre_r > pps_pkg::PRE_HALVE_MAX) begin
          if (p_r[pps_pkg::PER_W-1]) begin
            state_nxt = S_DONE;
          end else begin
            pre_nxt = pre_r >> 1;
            p_nxt   = p_r << 1;
          end
        end else begin
          state_nxt = S_NARROW;
        end
      end
      S_NARROW: begin
        if (!wide_i && p_r >= pps_pkg::P_NARROW_LIM) begin
          if (pre_r > pps_pkg::PRE_DOUBLE_MAX) begin
            state_nxt = S_DONE;
          end else begin
            pre_nxt = pre_r << 1;
            p_nxt   = p_r >> 1;
          end
        end else if (p_r == '0 || pre_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          div_req_o.start = 1'b1;
          div_req_o.num   = pps_pkg::NUM_W'(clk_hz_i);
          div_req_o.den   = pps_pkg::DEN_W'(pre_r);
          state_nxt       = S_CQ;
        end
      end
      S_CQ: begin
        if (div_rsp_i.done) begin
          cq_nxt          = div_rsp_i.quo[pps_pkg::CLK_W-1:0];
          div_req_o.start = 1'b1;
          div_req_o.num   = pps_pkg::NUM_W'(div_rsp_i.quo[pps_pkg::CLK_W-1:0]);
          div_req_o.den   = pps_pkg::DEN_W'(p_r);
          state_nxt       = S_D;
        end
      end
      S_D: begin
        if (div_rsp_i.done) begin
          if (quo32 == '0) begin
            state_nxt = S_DONE;
          end else begin
            div_req_o.start = 1'b1;
            div_req_o.num   = pps_pkg::NUM_W'(scale_r);
            div_req_o.den   = pps_pkg::DEN_W'(quo32);
            state_nxt       = S_P2;
          end
        end
      end
      S_P2: begin
        if (div_rsp_i.done) begin
          p2_nxt = quo32;
          if (quo32 == '0) begin
            state_nxt = S_DONE;
          end else begin
            div_req_o.start = 1'b1;
            div_req_o.num   = pps_pkg::NUM_W'(scale_r);
            div_req_o.den   = pps_pkg::DEN_W'(quo32);
            state_nxt       = S_A;
          end
        end
      end
      S_A: begin
        if (div_rsp_i.done) begin
          a_nxt     = quo32;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // step the period until the recomputed period reaches the base and the frequency no longer exceeds the target
        if (p2_r < base_r || a_k > pps_pkg::NUM_W'(f_r)) begin
          if (p_inc == '0) begin
            state_nxt = S_DONE;
          end else begin
            p_nxt           = p_inc;
            div_req_o.start = 1'b1;
            div_req_o.num   = pps_pkg::NUM_W'(cq_r);
            div_req_o.den   = pps_pkg::DEN_W'(p_inc);
            state_nxt       = S_D;
          end
        end else begin
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ok_r    <= ok_nxt;
    end
    f_r     <= f_nxt;
    scale_r <= scale_nxt;
    base_r  <= base_nxt;
    p_r     <= p_nxt;
    pre_r   <= pre_nxt;
    cq_r    <= cq_nxt;
    p2_r    <= p2_nxt;
    a_r     <= a_nxt;
  end

  assign idle_o             = (state_r == S_IDLE);
  assign res_o.valid        = (state_r == S_DONE);
  assign res_o.solved       = ok_r;
  assign res_o.prescale_div = ok_r ? pre_r[pps_pkg::PRE_W-1:0] : '0;
  assign res_o.period_count = ok_r ? p_r : '0;
  assign res_o.achieved_hz  = ok_r ? a_r[pps_pkg::CLK_W-1:0] : '0;

endmodule
`default_nettype wire

>>> design/pwm_prescaler_period_solver_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  handshake            word
// in_       in   in_valid/in_stall    target_millihertz[38:0]
// out_      out  out_valid/out_stall  solved, prescale_div[16:0], period_count[31:0],
//                                     achieved_hz[28:0]
// cfg_      in   cfg_valid/cfg_ready  cfg_index[1:0], cfg_wdata[28:0]
//
// One word at a time through a shared restoring divider.
// A solved word uses 6 + 3k divisions plus shift steps, where k is the number of
// period increments in the final search (two more divisions when the
// prescaler falls below one in the chosen scale).
// in_stall is high from acceptance until the result moves to the output register.
// Synchronous active-low reset; config regs reset to 108 MHz, 16-bit counter.
module pwm_prescaler_period_solver_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [pps_pkg::F_W-1:0]   in_target_millihertz,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_solved,
  output logic [pps_pkg::PRE_W-1:0]      out_prescale_div,
  output logic [pps_pkg::PER_W-1:0]      out_period_count,
  output logic [pps_pkg::CLK_W-1:0]      out_achieved_hz,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [pps_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [pps_pkg::CLK_W-1:0] cfg_wdata
);

  logic [pps_pkg::CLK_W-1:0] clk_hz_r;
  logic                      wide_r;
  logic                      out_valid_r;
  logic                      solved_r;
  logic [pps_pkg::PRE_W-1:0] prescale_r;
  logic [pps_pkg::PER_W-1:0] period_r;
  logic [pps_pkg::CLK_W-1:0] achieved_r;

  logic                      idle;
  logic                      in_take;
  logic                      out_free;
  logic                      res_take;
  pps_pkg::pps_res_t         res;
  pps_pkg::div_req_t         div_req;
  pps_pkg::div_rsp_t         div_rsp;

  assign cfg_ready = 1'b1;
  assign in_stall  = ~idle;
  assign in_take   = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign res_take  = res.valid & out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= pps_pkg::CLK_RESET;
      wide_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pps_pkg::REG_TIMER_CLOCK:  clk_hz_r <= cfg_wdata;
        pps_pkg::REG_COUNTER_WIDE: wide_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  pps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (in_take),
    .f_i        (in_target_millihertz),
    .clk_hz_i   (clk_hz_r),
    .wide_i     (wide_r),
    .idle_o     (idle),
    .res_o      (res),
    .res_take_i (res_take),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp)
  );

  pps_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      solved_r   <= res.solved;
      prescale_r <= res.prescale_div;
      period_r   <= res.period_count;
      achieved_r <= res.achieved_hz;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_solved       = solved_r;
  assign out_prescale_div = prescale_r;
  assign out_period_count = period_r;
  assign out_achieved_hz  = achieved_r;

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

import pps_pkg::*;

typedef struct packed {
  logic             solved;
  logic [PRE_W-1:0] prescale;
  logic [PER_W-1:0] period;
  logic [CLK_W-1:0] hz;
} pwm_setting_t;

class pwm_setting_scoreboard;
  logic [CLK_W-1:0] clock_hz;
  bit               wide;
  pwm_setting_t     expected_settings[$];
  int unsigned      errors;

  function new();
    clock_hz = CLK_RESET;
    wide = 1'b0;
    errors = 0;
  endfunction

  function void write_reg(logic [IDX_W-1:0] idx, logic [CLK_W-1:0] data);
    if (idx == REG_TIMER_CLOCK) begin
      clock_hz = data;
    end else if (idx == REG_COUNTER_WIDE) begin
      wide = data[0];
    end
  endfunction

  // prescaler / period search, exact integer form; steps counts period bumps
  function pwm_setting_t solve_setting(input logic [F_W-1:0] target,
                                       output int unsigned steps);
    bit [63:0] f;
    bit [31:0] clk_hz, scale, base, pre, p, d, p2, a, sm, cm;
    pwm_setting_t none;
    pwm_setting_t r;
    none = '0;
    steps = 0;
    f = 64'(target);
    clk_hz = 32'(clock_hz);
    if (f == 0) return none;
    // rounded base period, halves round up
    if (f >= 64'd1000000) begin
      scale = 32'd1000000000;
      base = 32'((64'd2000000000000 + f) / (2 * f));
    end else if (f >= 64'd1000) begin
      scale = 32'd1000000;
      base = 32'((64'd2000000000 + f) / (2 * f));
    end else begin
      scale = 32'd1000;
      base = 32'((64'd2000000 + f) / (2 * f));
    end
    p = base;
    pre = clk_hz / scale;
    if (pre == 0) begin
      sm = scale / 32'd1000000;
      cm = clk_hz / 32'd1000000;
      if (sm == 0) return none;
      if (p > 32'hFFFF_FFFF / 32'(MAX_CLK_MHZ)) begin
        pre = cm;
        p = p / sm;
      end else begin
        pre = 1;
        p = 32'(64'(p) * 64'(cm)) / sm;
      end
    end else begin
      while (pre > 32'h10000) begin
        if (p >= 32'h8000_0000) return none;
        pre = pre >> 1;
        p = p << 1;
      end
    end
    if (!wide) begin
      while (p >= 32'h10000) begin
        if (pre > 32'h8000) return none;
        pre = pre << 1;
        p = p >> 1;
      end
    end
    if (p == 0 || pre == 0) return none;
    forever begin
      d = (clk_hz / pre) / p;
      if (d == 0) return none;
      p2 = scale / d;
      if (p2 == 0) return none;
      a = scale / p2;
      if (p2 >= base && 64'(a) * 64'd1000 <= f) break;
      p = p + 1;
      steps++;
      if (p == 0) return none;
    end
    r.solved = 1'b1;
    r.prescale = PRE_W'(pre);
    r.period = p;
    r.hz = CLK_W'(a);
    return r;
  endfunction

  function void note_request(logic [F_W-1:0] target);
    int unsigned steps;
    expected_settings.push_back(solve_setting(target, steps));
  endfunction

  function void flag(string field, longint unsigned want, longint unsigned got);
    errors++;
    $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
  endfunction

  function void check_result(pwm_setting_t got);
    pwm_setting_t want;
    if (expected_settings.size() == 0) begin
      flag("unrequested word", 0, got.period);
      return;
    end
    want = expected_settings.pop_front();
    if (got.solved !== want.solved) flag("solved", want.solved, got.solved);
    if (got.prescale !== want.prescale) flag("prescale_div", want.prescale, got.prescale);
    if (got.period !== want.period) flag("period_count", want.period, got.period);
    if (got.hz !== want.hz) flag("achieved_hz", want.hz, got.hz);
  endfunction

  function int unsigned pending();
    return expected_settings.size();
  endfunction
endclass

module testbench;
  localparam logic [F_W-1:0]   F_MAX         = F_W'(64'd432000000000);
  localparam logic [IDX_W-1:0] REG_SPARE     = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_SPARE_TOP = IDX_W'(3);
  localparam int N_DIRECTED = 24;
  localparam logic [F_W-1:0] DIRECTED [N_DIRECTED] = '{
    F_W'(0), F_W'(1), F_W'(128), F_W'(500), F_W'(999), F_W'(1000), F_W'(1001),
    F_W'(1999), F_W'(2000), F_W'(2999), F_W'(640000), F_W'(999999),
    F_W'(1000000), F_W'(1000001), F_W'(20000000), F_W'(128000000),
    F_W'(1000000000), F_W'(123456789), F_W'(64'd54000000000),
    F_W'(64'd108000000000), F_W'(64'd274877906944), F_W'(64'd431999999999),
    F_W'(64'd432000000000), F_W'(64'd10000000000)
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [F_W-1:0]   in_target_millihertz = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_solved;
  logic [PRE_W-1:0] out_prescale_div;
  logic [PER_W-1:0] out_period_count;
  logic [CLK_W-1:0] out_achieved_hz;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CLK_W-1:0] cfg_wdata = '0;

  pwm_setting_scoreboard board;
  pwm_setting_t          out_word;
  int unsigned           src_idle_pct = 0;
  int unsigned           snk_stall_pct = 0;

  pwm_prescaler_period_solver_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_target_millihertz (in_target_millihertz),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_solved           (out_solved),
    .out_prescale_div     (out_prescale_div),
    .out_period_count     (out_period_count),
    .out_achieved_hz      (out_achieved_hz),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check accepted words, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      out_word.solved = out_solved;
      out_word.prescale = out_prescale_div;
      out_word.period = out_period_count;
      out_word.hz = out_achieved_hz;
      board.check_result(out_word);
    end
    out_stall <= ($urandom_range(0, 99) < snk_stall_pct);
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CLK_W-1:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
    board.write_reg(idx, data);
  endtask

  task automatic send_target(input logic [F_W-1:0] f);
    in_valid <= 1'b1;
    in_target_millihertz <= f;
    do @(posedge clk); while (in_stall);
    board.note_request(f);
  endtask

  task automatic wait_for_results();
    while (board.pending() != 0) @(posedge clk);
  endtask

  // random gap after a word; optionally hold off until the block is empty
  task automatic pause_sender(input bit drain);
    int unsigned n;
    n = 0;
    while ($urandom_range(0, 99) < src_idle_pct) n++;
    if (drain && n == 0) n = 1;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
      if (drain) wait_for_results();
    end
  endtask

  // mostly modest targets; long period searches are redrawn so runs stay short
  function automatic logic [F_W-1:0] pick_target();
    logic [63:0]  raw;
    logic [F_W-1:0] f;
    int unsigned  steps;
    int unsigned  budget;
    pwm_setting_t probe;
    budget = ($urandom_range(0, 24) == 0) ? 400 : 40;
    for (int tries = 0; tries < 200; tries++) begin
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 7))
        0:       f = F_W'($urandom_range(0, 999));
        1, 2:    f = F_W'($urandom_range(1000, 999999));
        3:       f = raw[F_W-1:0];
        default: f = raw[F_W-1:0] >> $urandom_range(0, 29);
      endcase
      if (f > F_MAX) f = f - F_MAX;
      probe = board.solve_setting(f, steps);
      if (steps <= budget) return f;
    end
    return '0;
  endfunction

  initial begin
    logic [CLK_W-1:0] phase_clk;
    bit               phase_wide;
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_target(DIRECTED[i]);
    in_valid <= 1'b0;
    wait_for_results();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin phase_clk = CLK_W'(432000000); phase_wide = 1'b1; end
        1: begin phase_clk = CLK_W'(1000000);   phase_wide = 1'b0; end
        2: begin phase_clk = CLK_W'(500000);    phase_wide = 1'b1; end // under 1 MHz
        3: begin phase_clk = CLK_W'(432000000); phase_wide = 1'b0; end
        4: begin phase_clk = CLK_W'(1000000);   phase_wide = 1'b1; end
        default: begin
          if ($urandom_range(0, 1))
            phase_clk = CLK_W'($urandom_range(1, 432) * 1000000);
          else
            phase_clk = CLK_W'($urandom_range(1000000, 432000000));
          phase_wide = $urandom_range(0, 1);
        end
      endcase
      if (ph == 5) begin
        // writes past the register list must not disturb anything
        write_reg(REG_SPARE, '1, 1'b0);
        write_reg(REG_SPARE_TOP, CLK_W'($urandom), 1'b0);
      end
      write_reg(REG_TIMER_CLOCK, phase_clk, 1'b0);
      write_reg(REG_COUNTER_WIDE, CLK_W'(phase_wide), 1'b1);
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 57; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 57; end
        default: begin src_idle_pct = 9; snk_stall_pct = 9; end
      endcase
      for (int i = 0; i < 40; i++) begin
        send_target(pick_target());
        if (i != 39) pause_sender(ph == 6 && i % 10 == 9);
      end
      in_valid <= 1'b0;
      wait_for_results();
    end

    snk_stall_pct = 0;
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Some tests failed");
    $finish;
  end
endmodule
